[rtl/y2r_pkg.sv]
// ----------------------------------------------------------------------------
// YUYV to RGB package
// Shared types, coefficients and the channel clamp for the YUYV converter.
// ----------------------------------------------------------------------------
package y2r_pkg;

  localparam int unsigned ChanW = 8;
  localparam int unsigned SumW  = 18;

  localparam logic signed [SumW-1:0] CoefRv = 18'sd359;
  localparam logic signed [SumW-1:0] CoefGu = 18'sd88;
  localparam logic signed [SumW-1:0] CoefGv = 18'sd183;
  localparam logic signed [SumW-1:0] CoefBu = 18'sd454;
  localparam logic [ChanW-1:0]       ChanMax = 8'd255;

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
  } rgb_t;

  function automatic logic [ChanW-1:0] clamp_chan(input logic signed [SumW-1:0] sum);
    logic [ChanW-1:0] res;
    if (sum[SumW-1]) begin
      res = '0;
    end else if (sum[SumW-2]) begin
      res = ChanMax;
    end else begin
      res = sum[SumW-3:SumW-2-ChanW];
    end
    return res;
  endfunction

endpackage

[rtl/y2r_pixel.sv]
// ----------------------------------------------------------------------------
// YUYV to RGB pixel converter
// Forms one RGB888 pixel from a luma byte and offset-free chroma in 8.8
// fixed point, with floor shift and clamp to 0..255.
// ----------------------------------------------------------------------------
module y2r_pixel
  import y2r_pkg::*;
(
  input  logic [ChanW-1:0]        luma_i,
  input  logic signed [ChanW-1:0] cb_i,
  input  logic signed [ChanW-1:0] cr_i,
  output rgb_t                    rgb_o
);

  logic signed [SumW-1:0] base;
  logic signed [SumW-1:0] cb_ext;
  logic signed [SumW-1:0] cr_ext;
  logic signed [SumW-1:0] sum_r;
  logic signed [SumW-1:0] sum_g;
  logic signed [SumW-1:0] sum_b;

  assign base   = $signed({2'b00, luma_i, 8'h00});
  assign cb_ext = SumW'(cb_i);
  assign cr_ext = SumW'(cr_i);

  assign sum_r = base + CoefRv * cr_ext;
  assign sum_g = base - CoefGu * cb_ext - CoefGv * cr_ext;
  assign sum_b = base + CoefBu * cb_ext;

  assign rgb_o.red   = clamp_chan(sum_r);
  assign rgb_o.green = clamp_chan(sum_g);
  assign rgb_o.blue  = clamp_chan(sum_b);

endmodule

[rtl/yuyv_to_rgb_fixed_point_unit.sv]
// ----------------------------------------------------------------------------
// YUYV to RGB888 converter
// Converts one YUYV macropixel to two RGB888 pixels per item.
//
//   channel  direction  handshake                 payload
//   in       input      in_valid_i / in_stall_o   luma, chroma, frame end
//   out      output     out_valid_o / out_stall_i two RGB pixels, frame end
//
// One item per cycle sustained while the output is not stalled; an item passes the
// input register, then the result register around the conversion logic.
// Reset clears both valid flags; payload registers are not reset.
// An empty input register still fills while a result is stalled, so the
// input stalls only when both stages hold an item.
// ----------------------------------------------------------------------------
module yuyv_to_rgb_fixed_point_unit
  import y2r_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [ChanW-1:0] luma_first_i,
  input  logic [ChanW-1:0] chroma_blue_i,
  input  logic [ChanW-1:0] luma_second_i,
  input  logic [ChanW-1:0] chroma_red_i,
  input  logic             frame_end_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [ChanW-1:0] red_first_o,
  output logic [ChanW-1:0] green_first_o,
  output logic [ChanW-1:0] blue_first_o,
  output logic [ChanW-1:0] red_second_o,
  output logic [ChanW-1:0] green_second_o,
  output logic [ChanW-1:0] blue_second_o,
  output logic             frame_end_out_o
);

  logic                    s1_valid_q;
  logic [ChanW-1:0]        luma0_q;
  logic [ChanW-1:0]        luma1_q;
  logic signed [ChanW-1:0] cb_q;
  logic signed [ChanW-1:0] cr_q;
  logic                    s1_frame_end_q;
  logic                    out_valid_q;
  rgb_t                    pix0_q;
  rgb_t                    pix1_q;
  rgb_t                    pix0_d;
  rgb_t                    pix1_d;
  logic                    frame_end_q;
  logic                    advance;
  logic                    s1_load;
  logic                    in_accept;

  assign advance   = !(out_valid_q && out_stall_i);
  assign s1_load   = advance || !s1_valid_q;
  assign in_stall_o = !s1_load;
  assign in_accept = in_valid_i && s1_load;

  y2r_pixel u_pix0 (
    .luma_i (luma0_q),
    .cb_i   (cb_q),
    .cr_i   (cr_q),
    .rgb_o  (pix0_d)
  );

  y2r_pixel u_pix1 (
    .luma_i (luma1_q),
    .cb_i   (cb_q),
    .cr_i   (cr_q),
    .rgb_o  (pix1_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_load) begin
        s1_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  // drop the offset of 128 by flipping the top bit
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      luma0_q        <= luma_first_i;
      luma1_q        <= luma_second_i;
      cb_q           <= {~chroma_blue_i[ChanW-1], chroma_blue_i[ChanW-2:0]};
      cr_q           <= {~chroma_red_i[ChanW-1], chroma_red_i[ChanW-2:0]};
      s1_frame_end_q <= frame_end_i;
    end
    if (advance && s1_valid_q) begin
      pix0_q      <= pix0_d;
      pix1_q      <= pix1_d;
      frame_end_q <= s1_frame_end_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign red_first_o     = pix0_q.red;
  assign green_first_o   = pix0_q.green;
  assign blue_first_o    = pix0_q.blue;
  assign red_second_o    = pix1_q.red;
  assign green_second_o  = pix1_q.green;
  assign blue_second_o   = pix1_q.blue;
  assign frame_end_out_o = frame_end_q;

  a_accept_fills_s1 : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> s1_valid_q)
    else $error("accepted item not held in input register");

  a_s1_moves_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && advance |=> out_valid_q)
    else $error("input register item lost on advance");

  a_stall_only_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q && out_valid_q)
    else $error("input stalled with a free stage");

  a_frame_end_follows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && advance |=> frame_end_out_o == $past(s1_frame_end_q))
    else $error("frame end flag not carried to result");

endmodule

[bench/tb_top.sv]
// ----------------------------------------------------------------------------
// YUYV to RGB888 converter testbench
// Sends YUYV macropixels through the valid/stall input channel. Each accepted
// item is converted in 8.8 fixed point by a local model, and each accepted
// result is checked field by field in order. The run covers directed extremes
// and clamp cases, a long receiver hold-off, a full drain, and a long random
// stream in which the sender works in bursts and the receiver stalls on its
// own pattern.
// ----------------------------------------------------------------------------
module tb_top
  import y2r_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RedFromV   = 359;
  localparam int GreenFromU = 88;
  localparam int GreenFromV = 183;
  localparam int BlueFromU  = 454;
  localparam int ChromaBias = 128;
  localparam int ChanTop    = 255;
  localparam int ReportMax  = 10;

  typedef struct packed {
    rgb_t first;
    rgb_t second;
    logic frame_end;
  } pixel_pair_t;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             in_valid_i;
  logic             in_stall_o;
  logic [ChanW-1:0] luma_first_i;
  logic [ChanW-1:0] chroma_blue_i;
  logic [ChanW-1:0] luma_second_i;
  logic [ChanW-1:0] chroma_red_i;
  logic             frame_end_i;
  logic             out_valid_o;
  logic             out_stall_i;
  logic [ChanW-1:0] red_first_o;
  logic [ChanW-1:0] green_first_o;
  logic [ChanW-1:0] blue_first_o;
  logic [ChanW-1:0] red_second_o;
  logic [ChanW-1:0] green_second_o;
  logic [ChanW-1:0] blue_second_o;
  logic             frame_end_out_o;

  pixel_pair_t pending_pairs[$];
  pixel_pair_t want_pair;
  int unsigned mismatches;
  int unsigned hold_request;
  bit          hold_active;

  yuyv_to_rgb_fixed_point_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .luma_first_i   (luma_first_i),
    .chroma_blue_i  (chroma_blue_i),
    .luma_second_i  (luma_second_i),
    .chroma_red_i   (chroma_red_i),
    .frame_end_i    (frame_end_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .red_first_o    (red_first_o),
    .green_first_o  (green_first_o),
    .blue_first_o   (blue_first_o),
    .red_second_o   (red_second_o),
    .green_second_o (green_second_o),
    .blue_second_o  (blue_second_o),
    .frame_end_out_o(frame_end_out_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [ChanW-1:0] fixed_to_channel(input int acc);
    int whole;
    whole = acc >>> 8;
    if (acc < 0) begin
      return '0;
    end
    if (whole > ChanTop) begin
      return ChanTop[ChanW-1:0];
    end
    return whole[ChanW-1:0];
  endfunction

  function automatic rgb_t luma_chroma_to_rgb(input int y, input int u, input int v);
    rgb_t px;
    int   base;
    base     = y * 256;
    px.red   = fixed_to_channel(base + RedFromV * v);
    px.green = fixed_to_channel(base - GreenFromU * u - GreenFromV * v);
    px.blue  = fixed_to_channel(base + BlueFromU * u);
    return px;
  endfunction

  function automatic pixel_pair_t yuyv_to_rgb_pair(
    input logic [ChanW-1:0] y0,
    input logic [ChanW-1:0] cb,
    input logic [ChanW-1:0] y1,
    input logic [ChanW-1:0] cr,
    input logic             fe
  );
    pixel_pair_t pair;
    int          u;
    int          v;
    u              = int'(cb) - ChromaBias;
    v              = int'(cr) - ChromaBias;
    pair.first     = luma_chroma_to_rgb(int'(y0), u, v);
    pair.second    = luma_chroma_to_rgb(int'(y1), u, v);
    pair.frame_end = fe;
    return pair;
  endfunction

  task automatic check_field(input string field, input int want_v, input int got_v);
    if (want_v != got_v) begin
      mismatches++;
      if (mismatches <= ReportMax) begin
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want_v, got_v);
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        pending_pairs.push_back(yuyv_to_rgb_pair(luma_first_i, chroma_blue_i,
                                                 luma_second_i, chroma_red_i, frame_end_i));
      end
      if (out_valid_o && !out_stall_i) begin
        if (pending_pairs.size() == 0) begin
          mismatches++;
          if (mismatches <= ReportMax) begin
            $display("%0t: result with no item pending", $time);
          end
        end else begin
          want_pair = pending_pairs.pop_front();
          check_field("red_first", int'(want_pair.first.red), int'(red_first_o));
          check_field("green_first", int'(want_pair.first.green), int'(green_first_o));
          check_field("blue_first", int'(want_pair.first.blue), int'(blue_first_o));
          check_field("red_second", int'(want_pair.second.red), int'(red_second_o));
          check_field("green_second", int'(want_pair.second.green), int'(green_second_o));
          check_field("blue_second", int'(want_pair.second.blue), int'(blue_second_o));
          check_field("frame_end_out", int'(want_pair.frame_end), int'(frame_end_out_o));
        end
      end
    end
  end

  initial begin
    int unsigned span;
    int unsigned go;
    int unsigned halt;
    wait (rst_ni);
    forever begin
      if (hold_request != 0) begin
        span         = hold_request;
        hold_request = 0;
        hold_active  = 1'b1;
        repeat (span) begin
          @(negedge clk_i);
          out_stall_i <= 1'b1;
        end
        hold_active = 1'b0;
      end else begin
        case ($urandom_range(0, 3))
          0: begin
            go   = $urandom_range(20, 60);
            halt = 0;
          end
          1: begin
            go   = 1;
            halt = $urandom_range(1, 3);
          end
          default: begin
            go   = $urandom_range(1, 8);
            halt = $urandom_range(0, 6);
          end
        endcase
        repeat (go) begin
          @(negedge clk_i);
          out_stall_i <= 1'b0;
        end
        repeat (halt) begin
          @(negedge clk_i);
          out_stall_i <= 1'b1;
        end
      end
    end
  end

  task automatic send_macropixel(
    input logic [ChanW-1:0] y0,
    input logic [ChanW-1:0] cb,
    input logic [ChanW-1:0] y1,
    input logic [ChanW-1:0] cr,
    input logic             fe
  );
    @(negedge clk_i);
    in_valid_i    <= 1'b1;
    luma_first_i  <= y0;
    chroma_blue_i <= cb;
    luma_second_i <= y1;
    chroma_red_i  <= cr;
    frame_end_i   <= fe;
    do begin
      @(posedge clk_i);
    end while (in_stall_o);
  endtask

  task automatic send_random_macropixel();
    send_macropixel(ChanW'($urandom_range(0, 255)), ChanW'($urandom_range(0, 255)),
                    ChanW'($urandom_range(0, 255)), ChanW'($urandom_range(0, 255)),
                    $urandom_range(0, 15) == 0);
  endtask

  task automatic idle_sender(input int unsigned cycles);
    repeat (cycles) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
  endtask

  task automatic wait_for_drain();
    idle_sender(1);
    while (pending_pairs.size() != 0) begin
      @(negedge clk_i);
    end
  endtask

  task automatic test_extremes();
    send_macropixel(8'd0, 8'd0, 8'd0, 8'd0, 1'b0);
    send_macropixel(8'd255, 8'd255, 8'd255, 8'd255, 1'b1);
    send_macropixel(8'd0, 8'd128, 8'd255, 8'd128, 1'b0);
    send_macropixel(8'd255, 8'd0, 8'd0, 8'd255, 1'b1);
    send_macropixel(8'd0, 8'd255, 8'd255, 8'd0, 1'b0);
    send_macropixel(8'd170, 8'd85, 8'd85, 8'd170, 1'b1);
    send_macropixel(8'd85, 8'd170, 8'd170, 8'd85, 1'b0);
    send_macropixel(8'd128, 8'd127, 8'd127, 8'd129, 1'b1);
    idle_sender(3);
  endtask

  task automatic test_clamping();
    send_macropixel(8'd0, 8'd0, 8'd1, 8'd0, 1'b0);
    send_macropixel(8'd255, 8'd255, 8'd254, 8'd255, 1'b0);
    send_macropixel(8'd0, 8'd255, 8'd2, 8'd255, 1'b0);
    send_macropixel(8'd255, 8'd0, 8'd250, 8'd0, 1'b1);
    send_macropixel(8'd1, 8'd127, 8'd1, 8'd127, 1'b0);
    send_macropixel(8'd1, 8'd128, 8'd0, 8'd127, 1'b0);
    send_macropixel(8'd255, 8'd128, 8'd254, 8'd128, 1'b0);
    send_macropixel(8'd200, 8'd200, 8'd60, 8'd60, 1'b1);
    send_macropixel(8'd30, 8'd140, 8'd220, 8'd20, 1'b0);
    send_macropixel(8'd16, 8'd128, 8'd235, 8'd128, 1'b1);
    idle_sender(2);
  endtask

  task automatic test_backpressure();
    wait_for_drain();
    hold_request = 80;
    wait (hold_active);
    repeat (24) begin
      send_random_macropixel();
    end
    idle_sender(1);
  endtask

  task automatic test_drain_pause();
    repeat (10) begin
      send_random_macropixel();
    end
    wait_for_drain();
    repeat (10) begin
      send_random_macropixel();
    end
    idle_sender(1);
  endtask

  task automatic test_random_stream();
    int unsigned sent;
    int unsigned burst;
    sent = 0;
    while (sent < 1000) begin
      burst = $urandom_range(1, 24);
      repeat (burst) begin
        send_random_macropixel();
        sent++;
      end
      if ($urandom_range(0, 3) != 0) begin
        idle_sender($urandom_range(1, 6));
      end
    end
    idle_sender(1);
  endtask

  initial begin
    int unsigned guard;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    luma_first_i  = '0;
    chroma_blue_i = '0;
    luma_second_i = '0;
    chroma_red_i  = '0;
    frame_end_i   = 1'b0;
    out_stall_i   = 1'b0;
    mismatches    = 0;
    hold_request  = 0;
    hold_active   = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_extremes();
    test_clamping();
    test_backpressure();
    test_drain_pause();
    test_random_stream();

    guard = 0;
    while (pending_pairs.size() != 0 && guard < 5000) begin
      @(negedge clk_i);
      guard++;
    end
    repeat (4) @(negedge clk_i);
    if (mismatches == 0 && pending_pairs.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
